FILE: rtl/log_stretch_pixel_top_defines.svh
// Assertion macros shared by the log stretch RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef LOG_STRETCH_PIXEL_TOP_DEFINES_SVH
`define LOG_STRETCH_PIXEL_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsp assertion failed");

`endif

FILE: rtl/lsp_pkg.sv
// Types, constants and fixed-point helper functions of the log stretch block.
// Has no dependencies; used by lsp_precomp and log_stretch_pixel_top.
package lsp_pkg;

  localparam int unsigned PixBits     = 16;
  localparam int unsigned FracBits    = 24;
  localparam int unsigned ScaleBits   = 14;
  localparam int unsigned BlackBits   = 16;
  localparam int unsigned ThrBits     = 17;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 17;

  localparam int unsigned MantW    = 31;
  localparam int unsigned MantFrac = MantW - 1;
  localparam int unsigned ArgW     = FracBits + ScaleBits + 1;
  localparam int unsigned KW       = $clog2(ArgW);
  localparam int unsigned LogIntW  = $clog2(ArgW - FracBits);
  localparam int unsigned LogW     = FracBits + LogIntW;
  localparam int unsigned NormW    = FracBits + 1;
  localparam int unsigned SpanW    = FracBits + 2;
  localparam int unsigned BsrW     = FracBits + PixBits + 1;
  localparam int unsigned YW       = LogW + NormW - FracBits;
  localparam int unsigned DivW     = LogW;
  localparam int unsigned QuoW     = 2 * FracBits + 1;
  localparam int unsigned DivCntW  = $clog2(QuoW);

  localparam logic [NormW-1:0]     OneQ       = {1'b1, {FracBits{1'b0}}};
  localparam logic [BlackBits-1:0] BlackMax   = {1'b1, {(BlackBits-1){1'b0}}};
  localparam logic [ScaleBits-1:0] ScaleReset = ScaleBits'(100);
  localparam logic [DivCntW-1:0]   ExpWide    = DivCntW'(2 * FracBits);
  localparam logic [DivCntW-1:0]   ExpSpan    = DivCntW'(FracBits + PixBits);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SCALE     = 2'd0,
    CFG_BLACK     = 2'd1,
    CFG_THRESHOLD = 2'd2
  } lsp_cfg_idx_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOD,
    SEQ_NRM,
    SEQ_SQR,
    SEQ_DIV,
    SEQ_TMUL,
    SEQ_TSCALE
  } lsp_seq_e;

  typedef enum logic [1:0] {
    DIV_NORM,
    DIV_SPAN,
    DIV_BLEND
  } lsp_div_e;

  typedef struct packed {
    logic [ScaleBits-1:0] scale;
    logic [BlackBits-1:0] black_eff;
    logic [FracBits-1:0]  tq;
    logic                 blend_en;
    logic [NormW-1:0]     norm_recip;
    logic [SpanW-1:0]     span_recip;
    logic [BsrW-1:0]      blend_recip;
    logic [NormW-1:0]     log_at_thr;
  } lsp_consts_t;

  function automatic logic [KW-1:0] lead_one(input logic [ArgW-1:0] a);
    logic [KW-1:0] k;
    k = '0;
    for (int i = 0; i < ArgW; i++) begin
      if (a[i]) k = KW'(i);
    end
    return k;
  endfunction

  function automatic logic [MantW-1:0] normalise(input logic [ArgW-1:0] a,
                                                 input logic [KW-1:0] k);
    logic [ArgW-1:0] s;
    if (k >= KW'(MantFrac)) begin
      s = a >> (k - KW'(MantFrac));
    end else begin
      s = a << (KW'(MantFrac) - k);
    end
    return s[MantW-1:0];
  endfunction

  // Returns the next fraction bit above the squared, renormalised mantissa.
  function automatic logic [MantW:0] square_step(input logic [MantW-1:0] m);
    logic [2*MantW-1:0] p;
    logic [MantW:0]     s;
    p = (2*MantW)'(m) * (2*MantW)'(m);
    s = p[MantFrac +: MantW+1];
    if (s[MantW]) begin
      return {1'b1, s[MantW:1]};
    end
    return {1'b0, s[MantW-1:0]};
  endfunction

  function automatic logic [LogW-1:0] log_word(input logic [KW-1:0] k,
                                               input logic [FracBits-1:0] frac);
    logic [KW-1:0] ip;
    ip = k - KW'(FracBits);
    return {ip[LogIntW-1:0], frac};
  endfunction

endpackage

FILE: rtl/lsp_precomp.sv
// Configuration registers and the sequencer that derives the per-configuration constants.
// Depends on lsp_pkg; shares one log2 squaring step and one restoring divider.
module lsp_precomp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lsp_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [lsp_pkg::CfgDataBits-1:0]  cfg_data_i,
  output logic                             busy_o,
  output lsp_pkg::lsp_consts_t             consts_o
);

  localparam int unsigned TprodW = lsp_pkg::LogW + lsp_pkg::NormW;

  lsp_pkg::lsp_seq_e state_q, state_d;
  logic kick_q, kick_d;
  logic [lsp_pkg::ScaleBits-1:0] scale_q, scale_d;
  logic [lsp_pkg::BlackBits-1:0] black_q, black_d;
  logic [lsp_pkg::ThrBits-1:0]   thr_q, thr_d;

  logic                          phase_q, phase_d;
  lsp_pkg::lsp_div_e             div_sel_q, div_sel_d;
  logic [lsp_pkg::ArgW-1:0]      arg_q, arg_d;
  logic [lsp_pkg::KW-1:0]        k_q, k_d;
  logic [lsp_pkg::MantW-1:0]     mant_q, mant_d;
  logic [lsp_pkg::FracBits-1:0]  frac_q, frac_d;
  logic [lsp_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [lsp_pkg::DivW-1:0]      rem_q, rem_d;
  logic [lsp_pkg::QuoW-1:0]      quo_q, quo_d;
  logic [lsp_pkg::LogW-1:0]      log_q, log_d;
  logic [lsp_pkg::NormW-1:0]     norm_q, norm_d;
  logic [lsp_pkg::SpanW-1:0]     span_q, span_d;
  logic [lsp_pkg::BsrW-1:0]      bsr_q, bsr_d;
  logic [lsp_pkg::NormW-1:0]     lat_q, lat_d;
  logic                          blend_en_q, blend_en_d;

  logic                          cfg_write;
  logic [lsp_pkg::BlackBits-1:0] black_eff;
  logic                          thr_en;
  logic [lsp_pkg::FracBits-1:0]  tq;
  logic [lsp_pkg::MantW:0]       sq_res;
  logic [lsp_pkg::FracBits-1:0]  frac_next;
  logic [lsp_pkg::LogW-1:0]      log_new;
  logic                          sq_last;
  logic [lsp_pkg::DivW-1:0]      divisor;
  logic [lsp_pkg::DivCntW-1:0]   div_exp;
  logic [lsp_pkg::DivW:0]        rtry;
  logic                          ge;
  logic [lsp_pkg::QuoW-1:0]      quo_next;
  logic [TprodW-1:0]             tprod;
  logic [lsp_pkg::YW-1:0]        lt;

  assign busy_o      = (state_q != lsp_pkg::SEQ_IDLE) || kick_q;
  assign cfg_ready_o = !busy_o;
  assign cfg_write   = cfg_valid_i && cfg_ready_o &&
                       ((cfg_index_i == lsp_pkg::CFG_SCALE) ||
                        (cfg_index_i == lsp_pkg::CFG_BLACK) ||
                        (cfg_index_i == lsp_pkg::CFG_THRESHOLD));

  always_comb begin
    black_eff = (black_q > lsp_pkg::BlackMax) ? lsp_pkg::BlackMax : black_q;
    thr_en    = (thr_q != '0) && !thr_q[lsp_pkg::ThrBits-1];
    tq        = {thr_q[lsp_pkg::PixBits-1:0], {(lsp_pkg::FracBits-lsp_pkg::PixBits){1'b0}}};
    sq_res    = lsp_pkg::square_step(mant_q);
    frac_next = {frac_q[lsp_pkg::FracBits-2:0], sq_res[lsp_pkg::MantW]};
    log_new   = lsp_pkg::log_word(k_q, frac_next);
    sq_last   = (cnt_q == lsp_pkg::DivCntW'(lsp_pkg::FracBits - 1));
    case (div_sel_q)
      lsp_pkg::DIV_NORM: begin
        divisor = log_q;
        div_exp = lsp_pkg::ExpWide;
      end
      lsp_pkg::DIV_SPAN: begin
        divisor = lsp_pkg::DivW'(({1'b1, {lsp_pkg::PixBits{1'b0}}}) -
                                 (lsp_pkg::PixBits+1)'(black_eff));
        div_exp = lsp_pkg::ExpSpan;
      end
      lsp_pkg::DIV_BLEND: begin
        divisor = lsp_pkg::DivW'(lsp_pkg::OneQ - lsp_pkg::NormW'(tq));
        div_exp = lsp_pkg::ExpWide;
      end
      default: begin
        divisor = log_q;
        div_exp = lsp_pkg::ExpWide;
      end
    endcase
    rtry     = {rem_q, (cnt_q == div_exp)};
    ge       = (rtry >= {1'b0, divisor});
    quo_next = {quo_q[lsp_pkg::QuoW-2:0], ge};
    tprod    = TprodW'(log_q) * TprodW'(norm_q);
    lt       = tprod[lsp_pkg::FracBits +: lsp_pkg::YW];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lsp_pkg::SEQ_IDLE: begin
        if (kick_q) state_d = lsp_pkg::SEQ_LOD;
      end
      lsp_pkg::SEQ_LOD:  state_d = lsp_pkg::SEQ_NRM;
      lsp_pkg::SEQ_NRM:  state_d = lsp_pkg::SEQ_SQR;
      lsp_pkg::SEQ_SQR: begin
        if (sq_last) state_d = phase_q ? lsp_pkg::SEQ_TSCALE : lsp_pkg::SEQ_DIV;
      end
      lsp_pkg::SEQ_DIV: begin
        if (cnt_q == '0) begin
          case (div_sel_q)
            lsp_pkg::DIV_NORM: state_d = lsp_pkg::SEQ_DIV;
            lsp_pkg::DIV_SPAN: state_d = thr_en ? lsp_pkg::SEQ_TMUL : lsp_pkg::SEQ_IDLE;
            default:           state_d = lsp_pkg::SEQ_IDLE;
          endcase
        end
      end
      lsp_pkg::SEQ_TMUL:   state_d = lsp_pkg::SEQ_LOD;
      lsp_pkg::SEQ_TSCALE: state_d = lsp_pkg::SEQ_DIV;
      default:             state_d = lsp_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    kick_d     = kick_q;
    scale_d    = scale_q;
    black_d    = black_q;
    thr_d      = thr_q;
    phase_d    = phase_q;
    div_sel_d  = div_sel_q;
    arg_d      = arg_q;
    k_d        = k_q;
    mant_d     = mant_q;
    frac_d     = frac_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    log_d      = log_q;
    norm_d     = norm_q;
    span_d     = span_q;
    bsr_d      = bsr_q;
    lat_d      = lat_q;
    blend_en_d = blend_en_q;

    if (cfg_write) begin
      kick_d = 1'b1;
      case (cfg_index_i)
        lsp_pkg::CFG_SCALE: scale_d = cfg_data_i[lsp_pkg::ScaleBits-1:0];
        lsp_pkg::CFG_BLACK: black_d = cfg_data_i[lsp_pkg::BlackBits-1:0];
        default:            thr_d   = cfg_data_i[lsp_pkg::ThrBits-1:0];
      endcase
    end

    case (state_q)
      lsp_pkg::SEQ_IDLE: begin
        if (kick_q) begin
          kick_d  = 1'b0;
          phase_d = 1'b0;
          arg_d   = (lsp_pkg::ArgW'(scale_q) + lsp_pkg::ArgW'(1)) << lsp_pkg::FracBits;
        end
      end
      lsp_pkg::SEQ_LOD: k_d = lsp_pkg::lead_one(arg_q);
      lsp_pkg::SEQ_NRM: begin
        mant_d = lsp_pkg::normalise(arg_q, k_q);
        frac_d = '0;
        cnt_d  = '0;
      end
      lsp_pkg::SEQ_SQR: begin
        mant_d = sq_res[lsp_pkg::MantW-1:0];
        frac_d = frac_next;
        cnt_d  = cnt_q + 1'b1;
        if (sq_last) begin
          log_d = log_new;
          rem_d = '0;
          quo_d = '0;
          if (!phase_q) begin
            if (log_new == '0) begin
              norm_d    = lsp_pkg::OneQ;
              div_sel_d = lsp_pkg::DIV_SPAN;
              cnt_d     = lsp_pkg::ExpSpan;
            end else begin
              div_sel_d = lsp_pkg::DIV_NORM;
              cnt_d     = lsp_pkg::ExpWide;
            end
          end
        end
      end
      lsp_pkg::SEQ_DIV: begin
        rem_d = ge ? rtry[lsp_pkg::DivW-1:0] - divisor : rtry[lsp_pkg::DivW-1:0];
        quo_d = quo_next;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          case (div_sel_q)
            lsp_pkg::DIV_NORM: begin
              norm_d    = quo_next[lsp_pkg::NormW-1:0];
              div_sel_d = lsp_pkg::DIV_SPAN;
              cnt_d     = lsp_pkg::ExpSpan;
              rem_d     = '0;
              quo_d     = '0;
            end
            lsp_pkg::DIV_SPAN: begin
              span_d = quo_next[lsp_pkg::SpanW-1:0];
              if (!thr_en) begin
                bsr_d      = '0;
                lat_d      = '0;
                blend_en_d = 1'b0;
              end
            end
            default: begin
              bsr_d      = quo_next[lsp_pkg::BsrW-1:0];
              blend_en_d = 1'b1;
            end
          endcase
        end
      end
      lsp_pkg::SEQ_TMUL: begin
        phase_d = 1'b1;
        arg_d   = lsp_pkg::ArgW'(lsp_pkg::OneQ) +
                  lsp_pkg::ArgW'(scale_q) * lsp_pkg::ArgW'(tq);
      end
      lsp_pkg::SEQ_TSCALE: begin
        lat_d     = (lt > lsp_pkg::YW'(lsp_pkg::OneQ)) ? lsp_pkg::OneQ :
                                                        lt[lsp_pkg::NormW-1:0];
        div_sel_d = lsp_pkg::DIV_BLEND;
        cnt_d     = lsp_pkg::ExpWide;
        rem_d     = '0;
        quo_d     = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsp_pkg::SEQ_IDLE;
      kick_q  <= 1'b1;
      scale_q <= lsp_pkg::ScaleReset;
      black_q <= '0;
      thr_q   <= '0;
    end else begin
      state_q <= state_d;
      kick_q  <= kick_d;
      scale_q <= scale_d;
      black_q <= black_d;
      thr_q   <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q    <= phase_d;
    div_sel_q  <= div_sel_d;
    arg_q      <= arg_d;
    k_q        <= k_d;
    mant_q     <= mant_d;
    frac_q     <= frac_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    log_q      <= log_d;
    norm_q     <= norm_d;
    span_q     <= span_d;
    bsr_q      <= bsr_d;
    lat_q      <= lat_d;
    blend_en_q <= blend_en_d;
  end

  always_comb begin
    consts_o.scale       = scale_q;
    consts_o.black_eff   = black_eff;
    consts_o.tq          = tq;
    consts_o.blend_en    = blend_en_q;
    consts_o.norm_recip  = norm_q;
    consts_o.span_recip  = span_q;
    consts_o.blend_recip = bsr_q;
    consts_o.log_at_thr  = lat_q;
  end

endmodule

FILE: rtl/log_stretch_pixel_top.sv
// Log stretch pixel pipeline; depends on lsp_pkg, lsp_precomp and the assertion macro header.
// One pixel per cycle is accepted while busy is low; result_valid_o marks each result.
// The depth is set by the 24 stages of the log2 unit, one mantissa squaring per stage.
// After reset and after each register write the constant sequencer runs, for longer with the
// highlight blend on and for less at zero scale; busy is high meanwhile.
// Results cannot stall.
`include "log_stretch_pixel_top_defines.svh"

module log_stretch_pixel_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [lsp_pkg::PixBits-1:0]      pixel_in_i,
  output logic [lsp_pkg::PixBits-1:0]      pixel_out_o,
  output logic                             result_valid_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lsp_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [lsp_pkg::CfgDataBits-1:0]  cfg_data_i
);

  localparam int unsigned Sq       = lsp_pkg::FracBits;
  localparam int unsigned Latency  = Sq + 11;
  localparam int unsigned F        = lsp_pkg::FracBits;
  localparam int unsigned NW       = lsp_pkg::NormW;
  localparam int unsigned P2W      = lsp_pkg::PixBits + lsp_pkg::SpanW;
  localparam int unsigned YProdW   = lsp_pkg::LogW + NW;
  localparam int unsigned PhiW     = lsp_pkg::BsrW;
  localparam int unsigned PloW     = 2 * F;
  localparam int unsigned WrW      = lsp_pkg::BsrW + 1;
  localparam int unsigned W2ProdW  = 2 * NW;
  localparam int unsigned LinW     = NW + 1;
  localparam int unsigned M1ProdW  = lsp_pkg::YW + NW;
  localparam int unsigned M1W      = M1ProdW - F;
  localparam int unsigned M2ProdW  = LinW + NW;
  localparam int unsigned M2W      = M2ProdW - F;
  localparam int unsigned SumW     = M1W + 1;
  localparam int unsigned ResW     = lsp_pkg::PixBits + 1;
  localparam int unsigned Drop     = F - lsp_pkg::PixBits;
  localparam logic [NW-1:0] RoundHalf = NW'(1) << (Drop - 1);

  lsp_pkg::lsp_consts_t c;

  lsp_precomp u_precomp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .consts_o    (c)
  );

  logic [Latency-1:0] vld_q;

  logic [lsp_pkg::PixBits-1:0] v1_q;
  logic                        zero2_q;
  logic [P2W-1:0]              p2_q;
  logic                        zero3_q, full3_q;
  logic [F-1:0]                x3_q;
  logic [lsp_pkg::ArgW-1:0]    arg3_q;
  logic                        zero4_q, full4_q;
  logic [F-1:0]                x4_q;
  logic [lsp_pkg::ArgW-1:0]    arg4_q;
  logic [lsp_pkg::KW-1:0]      k4_q;

  logic [lsp_pkg::MantW-1:0]   sq_m_q    [0:Sq];
  logic [F-1:0]                sq_f_q    [0:Sq];
  logic [lsp_pkg::KW-1:0]      sq_k_q    [0:Sq];
  logic [F-1:0]                sq_x_q    [0:Sq];
  logic                        sq_zero_q [0:Sq];
  logic                        sq_full_q [0:Sq];
  logic [lsp_pkg::MantW:0]     sq_res    [0:Sq-1];

  logic [lsp_pkg::YW-1:0]      yy_q, ya_q, yw_q, yl_q, ym_q;
  logic [F-1:0]                xy_q;
  logic [4:0]                  zero_t_q, full_t_q;
  logic [3:0]                  gt_t_q;
  logic [PhiW-1:0]             phi_q;
  logic [PloW-1:0]             plo_q;
  logic [NW-1:0]               w_q, w2_q;
  logic [LinW-1:0]             lin_q;
  logic [M1W-1:0]              m1_q;
  logic [M2W-1:0]              m2_q;
  logic [lsp_pkg::PixBits-1:0] pixel_out_q;

  logic                        low2;
  logic [lsp_pkg::PixBits-1:0] d2;
  logic [P2W-1:0]              p2_d;
  logic [lsp_pkg::SpanW-1:0]   x3;
  logic [lsp_pkg::ArgW-1:0]    arg3_d;
  logic [lsp_pkg::LogW-1:0]    logv;
  logic [YProdW-1:0]           yprod;
  logic                        gt;
  logic [F-1:0]                dx;
  logic [WrW-1:0]              wr;
  logic [W2ProdW-1:0]          pw2, plin;
  logic [M1ProdW-1:0]          pm1;
  logic [M2ProdW-1:0]          pm2;
  logic [SumW-1:0]             ysum;
  logic [NW-1:0]               yc, rnd;
  logic [ResW-1:0]             res;
  logic [lsp_pkg::PixBits-1:0] pixel_out_d;
  logic                        cfg_wr_ok;

  always_comb begin
    low2   = (v1_q <= c.black_eff);
    d2     = v1_q - c.black_eff;
    p2_d   = P2W'(d2) * P2W'(c.span_recip);
    x3     = p2_q[lsp_pkg::PixBits +: lsp_pkg::SpanW];
    arg3_d = lsp_pkg::ArgW'(lsp_pkg::OneQ) +
             lsp_pkg::ArgW'(c.scale) * lsp_pkg::ArgW'(x3[F-1:0]);
    for (int i = 0; i < Sq; i++) begin
      sq_res[i] = lsp_pkg::square_step(sq_m_q[i]);
    end
    logv  = lsp_pkg::log_word(sq_k_q[Sq], sq_f_q[Sq]);
    yprod = YProdW'(logv) * YProdW'(c.norm_recip);
    gt    = c.blend_en && (xy_q > c.tq);
    dx    = xy_q - c.tq;
    wr    = WrW'(phi_q) + WrW'(plo_q[PloW-1:F]);
    pw2   = W2ProdW'(w_q) * W2ProdW'(w_q);
    plin  = W2ProdW'(w_q) * W2ProdW'(lsp_pkg::OneQ - c.log_at_thr);
    pm1   = M1ProdW'(yl_q) * M1ProdW'(lsp_pkg::OneQ - w2_q);
    pm2   = M2ProdW'(lin_q) * M2ProdW'(w2_q);
    ysum  = gt_t_q[3] ? (SumW'(m1_q) + SumW'(m2_q)) : SumW'(ym_q);
    yc    = (ysum > SumW'(lsp_pkg::OneQ)) ? lsp_pkg::OneQ : ysum[NW-1:0];
    rnd   = yc + RoundHalf;
    res   = rnd[Drop +: ResW];
    if (zero_t_q[4]) begin
      pixel_out_d = '0;
    end else if (full_t_q[4] || res[lsp_pkg::PixBits]) begin
      pixel_out_d = '1;
    end else begin
      pixel_out_d = res[lsp_pkg::PixBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    v1_q    <= pixel_in_i;
    zero2_q <= low2;
    p2_q    <= p2_d;
    zero3_q <= zero2_q;
    full3_q <= |x3[lsp_pkg::SpanW-1:F];
    x3_q    <= x3[F-1:0];
    arg3_q  <= arg3_d;
    zero4_q <= zero3_q;
    full4_q <= full3_q;
    x4_q    <= x3_q;
    arg4_q  <= arg3_q;
    k4_q    <= lsp_pkg::lead_one(arg3_q);

    sq_m_q[0]    <= lsp_pkg::normalise(arg4_q, k4_q);
    sq_f_q[0]    <= '0;
    sq_k_q[0]    <= k4_q;
    sq_x_q[0]    <= x4_q;
    sq_zero_q[0] <= zero4_q;
    sq_full_q[0] <= full4_q;
    for (int i = 0; i < Sq; i++) begin
      sq_m_q[i+1]    <= sq_res[i][lsp_pkg::MantW-1:0];
      sq_f_q[i+1]    <= {sq_f_q[i][F-2:0], sq_res[i][lsp_pkg::MantW]};
      sq_k_q[i+1]    <= sq_k_q[i];
      sq_x_q[i+1]    <= sq_x_q[i];
      sq_zero_q[i+1] <= sq_zero_q[i];
      sq_full_q[i+1] <= sq_full_q[i];
    end

    yy_q     <= yprod[F +: lsp_pkg::YW];
    xy_q     <= sq_x_q[Sq];
    zero_t_q <= {zero_t_q[3:0], sq_zero_q[Sq]};
    full_t_q <= {full_t_q[3:0], sq_full_q[Sq]};

    ya_q   <= yy_q;
    gt_t_q <= {gt_t_q[2:0], gt};
    phi_q  <= PhiW'(dx) * PhiW'(c.blend_recip[lsp_pkg::BsrW-1:F]);
    plo_q  <= PloW'(dx) * PloW'(c.blend_recip[F-1:0]);

    yw_q <= ya_q;
    w_q  <= (wr > WrW'(lsp_pkg::OneQ)) ? lsp_pkg::OneQ : wr[NW-1:0];

    yl_q  <= yw_q;
    w2_q  <= pw2[F +: NW];
    lin_q <= LinW'(c.log_at_thr) + LinW'(plin[F +: NW]);

    ym_q <= yl_q;
    m1_q <= pm1[F +: M1W];
    m2_q <= pm2[F +: M2W];

    pixel_out_q <= pixel_out_d;
  end

  assign pixel_out_o    = pixel_out_q;
  assign result_valid_o = vld_q[Latency-1];

  assign cfg_wr_ok = cfg_valid_i && cfg_ready_o &&
                     ((cfg_index_i == lsp_pkg::CFG_SCALE) ||
                      (cfg_index_i == lsp_pkg::CFG_BLACK) ||
                      (cfg_index_i == lsp_pkg::CFG_THRESHOLD));

  `LSP_ASSERT_IMPLY(a_result_follows, clk_i, rst_ni, start && !busy, ##35 result_valid_o)
  `LSP_ASSERT_IMPLY(a_no_phantom, clk_i, rst_ni, result_valid_o, $past(start && !busy, 35))
  `LSP_ASSERT_NEXT(a_write_recomputes, clk_i, rst_ni, cfg_wr_ok, busy)

endmodule
